@@ rtl/core/sss_pkg.sv @@
// shared types and constants of the servo speed sequencer
`default_nettype none

package sss_pkg;

  // widths of the register write port and of the integrator
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 47;
  localparam int unsigned IntegW   = 48;

  // operating modes, coded as seen on machine_state
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_POWERON = 3'd1,
    MODE_INIT    = 3'd2,
    MODE_RAMPING = 3'd3,
    MODE_STEADY  = 3'd4,
    MODE_DECEL   = 3'd5,
    MODE_FAULT   = 3'd6,
    MODE_ESTOP   = 3'd7
  } mode_e;

  // request command codes
  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_POWER_ON     = 3'd1,
    CMD_SET_TARGET   = 3'd2,
    CMD_DECELERATE   = 3'd3,
    CMD_ESTOP        = 3'd4,
    CMD_CLEAR_FAULT  = 3'd5,
    CMD_INJECT_FAULT = 3'd6
  } cmd_e;

  // register indexes of the write port
  typedef enum logic [2:0] {
    CFG_SPEED_KP        = 3'd0,
    CFG_KI_TIMES_PERIOD = 3'd1,
    CFG_INTEG_LIMIT     = 3'd2,
    CFG_CURRENT_LIMIT   = 3'd3,
    CFG_RAMP_STEP       = 3'd4,
    CFG_POWERON_TICKS   = 3'd5,
    CFG_SETTLE_BAND     = 3'd6,
    CFG_STOP_SPEED      = 3'd7
  } cfg_idx_e;

  // what happens to the current command for one request
  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_ZERO = 2'd1,
    ACT_PI   = 2'd2
  } act_e;

  // register reset values
  localparam logic [31:0] SpeedKpRst       = 32'd3277;
  localparam logic [31:0] KiTimesPeriodRst = 32'd858993;
  localparam logic [46:0] IntegLimitRst    = 47'd13107200000;
  localparam logic [30:0] CurrentLimitRst  = 31'd983040;
  localparam logic [30:0] RampStepRst      = 31'd655;
  localparam logic [31:0] PoweronTicksRst  = 32'd500;
  localparam logic [30:0] SettleBandRst    = 31'd65536;
  localparam logic [30:0] StopSpeedRst     = 31'd65536;

  // configuration registers
  typedef struct packed {
    logic [31:0] speed_kp;
    logic [31:0] ki_times_period;
    logic [46:0] integ_limit;
    logic [30:0] current_limit;
    logic [30:0] ramp_step;
    logic [31:0] poweron_ticks;
    logic [30:0] settle_band;
    logic [30:0] stop_speed;
  } cfg_t;

  // one request as held in the input register
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] target_speed;
    logic signed [31:0] measured_speed;
    logic signed [31:0] measured_current;
  } item_t;

  // sequencing stage to multiply stage
  typedef struct packed {
    mode_e                    mode;
    logic signed [31:0]       ramp;
    act_e                     act;
    logic signed [32:0]       err;
    logic signed [IntegW-1:0] integ;
  } seq_out_t;

  // multiply stage to combine stage
  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] ramp;
    act_e               act;
    logic               err_neg;
    logic               integ_neg;
    logic [64:0]        p_prod;
    logic [63:0]        i_lo_prod;
    logic [46:0]        i_hi_prod;
  } mul_out_t;

  // one result
  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] current_command;
    logic signed [31:0] ramp_reference;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/sss_if.sv @@
// request and result channels of the servo speed sequencer
`default_nettype none

interface sss_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] target_speed;
  logic signed [31:0] measured_speed;
  logic signed [31:0] measured_current;

  modport source (
    output valid, cmd, target_speed, measured_speed, measured_current,
    input  ready
  );
  modport sink (
    input  valid, cmd, target_speed, measured_speed, measured_current,
    output ready
  );
endinterface

interface sss_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         machine_state;
  logic signed [31:0] current_command;
  logic signed [31:0] ramp_reference;

  modport source (
    output valid, machine_state, current_command, ramp_reference,
    input  ready
  );
  modport sink (
    input  valid, machine_state, current_command, ramp_reference,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/servo_speed_sequencer_pi.sv @@
// servo speed sequencer top level: register file, request register and pipeline
// One request enters per clock unless stalled, and its result leaves through
// the request register, sequencing stage, multiply stage and result register.
// The throughput of one request per cycle is held by the sequencing stage,
// which closes the mode, ramp, tick count and integrator update before the next
// request; the PI products are formed afterwards on registered operands and do
// not feed back. Every request, ticks and commands alike and the unused code
// too, gives exactly one result: the mode, the current command (held between
// ticks) and the ramp reference. Registers are written through the plain
// write port and should only be changed while no request is in flight.
`default_nettype none

module servo_speed_sequencer_pi (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  sss_req_if.sink                               req_i,
  sss_rsp_if.source                             rsp_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [sss_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [sss_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  sss_pkg::cfg_t     cfg_q;
  logic              in_valid_q, in_valid_d, seq_ready, req_fire;
  sss_pkg::item_t    in_q;
  logic              seq_valid, pi_ready;
  sss_pkg::seq_out_t seq_data;
  sss_pkg::res_t     res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_kp        <= sss_pkg::SpeedKpRst;
      cfg_q.ki_times_period <= sss_pkg::KiTimesPeriodRst;
      cfg_q.integ_limit     <= sss_pkg::IntegLimitRst;
      cfg_q.current_limit   <= sss_pkg::CurrentLimitRst;
      cfg_q.ramp_step       <= sss_pkg::RampStepRst;
      cfg_q.poweron_ticks   <= sss_pkg::PoweronTicksRst;
      cfg_q.settle_band     <= sss_pkg::SettleBandRst;
      cfg_q.stop_speed      <= sss_pkg::StopSpeedRst;
    end else if (cfg_we_i) begin
      unique case (sss_pkg::cfg_idx_e'(cfg_idx_i))
        sss_pkg::CFG_SPEED_KP:        cfg_q.speed_kp        <= cfg_wdata_i[31:0];
        sss_pkg::CFG_KI_TIMES_PERIOD: cfg_q.ki_times_period <= cfg_wdata_i[31:0];
        sss_pkg::CFG_INTEG_LIMIT:     cfg_q.integ_limit     <= cfg_wdata_i[46:0];
        sss_pkg::CFG_CURRENT_LIMIT:   cfg_q.current_limit   <= cfg_wdata_i[30:0];
        sss_pkg::CFG_RAMP_STEP:       cfg_q.ramp_step       <= cfg_wdata_i[30:0];
        sss_pkg::CFG_POWERON_TICKS:   cfg_q.poweron_ticks   <= cfg_wdata_i[31:0];
        sss_pkg::CFG_SETTLE_BAND:     cfg_q.settle_band     <= cfg_wdata_i[30:0];
        sss_pkg::CFG_STOP_SPEED:      cfg_q.stop_speed      <= cfg_wdata_i[30:0];
        default: begin
        end
      endcase
    end
  end

  // request register
  assign req_i.ready = !in_valid_q || seq_ready;
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    if (req_fire) begin
      in_valid_d = 1'b1;
    end else if (seq_ready) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q.cmd              <= req_i.cmd;
      in_q.target_speed     <= req_i.target_speed;
      in_q.measured_speed   <= req_i.measured_speed;
      in_q.measured_current <= req_i.measured_current;
    end
  end

  // mode machine and integrator
  sss_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (seq_ready),
    .in_item_i   (in_q),
    .out_valid_o (seq_valid),
    .out_ready_i (pi_ready),
    .out_data_o  (seq_data)
  );

  // pi products and command clamp
  sss_pi u_pi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (seq_valid),
    .in_ready_o  (pi_ready),
    .in_data_i   (seq_data),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (res)
  );

  assign rsp_o.machine_state   = res.mode;
  assign rsp_o.current_command = res.current_command;
  assign rsp_o.ramp_reference  = res.ramp_reference;

endmodule

`default_nettype wire

@@ rtl/core/sss_seq.sv @@
// sequencing stage: mode machine, ramp, tick count and integrator update
`default_nettype none

module sss_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sss_pkg::cfg_t    cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sss_pkg::item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sss_pkg::seq_out_t     out_data_o
);

  sss_pkg::mode_e     mode_q, mode_d;
  logic signed [31:0] target_q, target_d;
  logic signed [31:0] ramp_q, ramp_d;
  logic signed [sss_pkg::IntegW-1:0] integ_q, integ_d;
  logic [31:0]        tick_q, tick_d, tick_inc;
  logic               out_valid_q, out_valid_d;
  sss_pkg::seq_out_t  out_data_q;
  sss_pkg::act_e      act;
  logic               fire;

  logic [32:0]        cur_mag, diff_mag, settle_mag, step33;
  logic signed [32:0] cur_ext, diff, ramp_sum, settle_diff, ramp_dec, err;
  logic signed [31:0] ramp_ramp, ramp_decel, pi_ref;
  logic               over_cur, settled, stopped, diff_pos;
  logic signed [sss_pkg::IntegW:0] integ_sum, lim_pos, lim_neg;
  logic signed [sss_pkg::IntegW-1:0] integ_pi;

  // handshake: take a request whenever the output register frees up
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // datapath shared by the tick cases
  always_comb begin
    tick_inc = (tick_q != 32'hFFFF_FFFF) ? tick_q + 32'd1 : tick_q;
    step33   = {2'b00, cfg_i.ramp_step};

    // over-current check on the magnitude of the sensed current
    cur_ext  = {in_item_i.measured_current[31], in_item_i.measured_current};
    cur_mag  = cur_ext[32] ? 33'(-cur_ext) : 33'(cur_ext);
    over_cur = (mode_q != sss_pkg::MODE_FAULT) && (mode_q != sss_pkg::MODE_ESTOP) &&
               (cur_mag > {2'b00, cfg_i.current_limit});

    // slew-limited step toward the target
    diff     = {target_q[31], target_q} - {ramp_q[31], ramp_q};
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    diff_pos = !diff[32] && (diff != 33'sd0);
    ramp_sum = {ramp_q[31], ramp_q} + (diff_pos ? $signed(step33) : -$signed(step33));
    ramp_ramp = (diff_mag < step33) ? target_q : ramp_sum[31:0];

    settle_diff = {ramp_ramp[31], ramp_ramp} - {target_q[31], target_q};
    settle_mag  = settle_diff[32] ? 33'(-settle_diff) : 33'(settle_diff);
    settled     = settle_mag < {2'b00, cfg_i.settle_band};

    // deceleration floors at zero
    ramp_dec   = {ramp_q[31], ramp_q} - $signed(step33);
    ramp_decel = ramp_dec[32] ? 32'sd0 : ramp_dec[31:0];
    stopped    = in_item_i.measured_speed < $signed({1'b0, cfg_i.stop_speed});

    // speed error and clamped integrator
    unique case (mode_q)
      sss_pkg::MODE_RAMPING: pi_ref = ramp_ramp;
      sss_pkg::MODE_DECEL:   pi_ref = ramp_decel;
      default:               pi_ref = target_q;
    endcase
    err       = {pi_ref[31], pi_ref} -
                {in_item_i.measured_speed[31], in_item_i.measured_speed};
    integ_sum = {integ_q[sss_pkg::IntegW-1], integ_q} +
                {{(sss_pkg::IntegW-32){err[32]}}, err};
    lim_pos   = {2'b00, cfg_i.integ_limit};
    lim_neg   = -lim_pos;
    if (integ_sum > lim_pos) begin
      integ_pi = lim_pos[sss_pkg::IntegW-1:0];
    end else if (integ_sum < lim_neg) begin
      integ_pi = lim_neg[sss_pkg::IntegW-1:0];
    end else begin
      integ_pi = integ_sum[sss_pkg::IntegW-1:0];
    end
  end

  // next state per command
  always_comb begin
    mode_d   = mode_q;
    target_d = target_q;
    ramp_d   = ramp_q;
    integ_d  = integ_q;
    tick_d   = tick_q;
    act      = sss_pkg::ACT_HOLD;
    unique case (sss_pkg::cmd_e'(in_item_i.cmd))
      sss_pkg::CMD_TICK: begin
        tick_d = tick_inc;
        if (over_cur) begin
          mode_d  = sss_pkg::MODE_FAULT;
          integ_d = '0;
          act     = sss_pkg::ACT_ZERO;
        end else begin
          unique case (mode_q)
            sss_pkg::MODE_POWERON: begin
              if (tick_inc > cfg_i.poweron_ticks) mode_d = sss_pkg::MODE_INIT;
            end
            sss_pkg::MODE_INIT: begin
              integ_d = '0;
              mode_d  = sss_pkg::MODE_IDLE;
            end
            sss_pkg::MODE_RAMPING: begin
              ramp_d  = ramp_ramp;
              integ_d = integ_pi;
              act     = sss_pkg::ACT_PI;
              if (settled) mode_d = sss_pkg::MODE_STEADY;
            end
            sss_pkg::MODE_STEADY: begin
              integ_d = integ_pi;
              act     = sss_pkg::ACT_PI;
            end
            sss_pkg::MODE_DECEL: begin
              ramp_d  = ramp_decel;
              integ_d = integ_pi;
              act     = sss_pkg::ACT_PI;
              if (stopped) begin
                mode_d = sss_pkg::MODE_IDLE;
                ramp_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      sss_pkg::CMD_POWER_ON: begin
        if (mode_q == sss_pkg::MODE_IDLE) mode_d = sss_pkg::MODE_POWERON;
      end
      sss_pkg::CMD_SET_TARGET: begin
        target_d = in_item_i.target_speed;
        if (mode_q == sss_pkg::MODE_IDLE || mode_q == sss_pkg::MODE_STEADY ||
            mode_q == sss_pkg::MODE_POWERON || mode_q == sss_pkg::MODE_INIT) begin
          mode_d = sss_pkg::MODE_RAMPING;
        end
      end
      sss_pkg::CMD_DECELERATE: begin
        if (mode_q == sss_pkg::MODE_STEADY || mode_q == sss_pkg::MODE_RAMPING) begin
          target_d = '0;
          mode_d   = sss_pkg::MODE_DECEL;
        end
      end
      sss_pkg::CMD_ESTOP: begin
        mode_d  = sss_pkg::MODE_ESTOP;
        integ_d = '0;
        act     = sss_pkg::ACT_ZERO;
      end
      sss_pkg::CMD_CLEAR_FAULT: begin
        if (mode_q == sss_pkg::MODE_FAULT) begin
          integ_d = '0;
          ramp_d  = '0;
          mode_d  = sss_pkg::MODE_IDLE;
        end
      end
      sss_pkg::CMD_INJECT_FAULT: begin
        mode_d  = sss_pkg::MODE_FAULT;
        integ_d = '0;
      end
      default: begin
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= sss_pkg::MODE_IDLE;
      target_q    <= '0;
      ramp_q      <= '0;
      integ_q     <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        mode_q   <= mode_d;
        target_q <= target_d;
        ramp_q   <= ramp_d;
        integ_q  <= integ_d;
        tick_q   <= tick_d;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q.mode  <= mode_d;
      out_data_q.ramp  <= ramp_d;
      out_data_q.act   <= act;
      out_data_q.err   <= err;
      out_data_q.integ <= integ_pi;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sss_pi.sv @@
// pi output stages: registered products, then sum, clamp and command hold
`default_nettype none

module sss_pi (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sss_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sss_pkg::seq_out_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sss_pkg::res_t          out_data_o
);

  logic               mul_valid_q, mul_valid_d, mul_ready, mul_fire;
  sss_pkg::mul_out_t  mul_q, mul_d;
  logic               res_valid_q, res_valid_d, res_fire;
  sss_pkg::mode_e     res_mode_q;
  logic signed [31:0] res_ramp_q;
  logic signed [31:0] res_cmd_q, res_cmd_d;

  logic [32:0]        err_mag;
  logic [sss_pkg::IntegW-1:0] integ_mag;
  logic [48:0]        p_mag;
  logic [47:0]        i_mag;
  logic signed [50:0] p_s, i_s, u, cl_pos, cl_neg;
  logic signed [31:0] cmd_pi;

  // handshake through both stages, bubbles collapse
  assign mul_ready   = !res_valid_q || out_ready_i;
  assign in_ready_o  = !mul_valid_q || mul_ready;
  assign mul_fire    = in_valid_i && in_ready_o;
  assign res_fire    = mul_valid_q && mul_ready;
  assign out_valid_o = res_valid_q;

  // multiply on magnitudes, integral product split at bit 32
  always_comb begin
    err_mag   = in_data_i.err[32] ? 33'(-in_data_i.err) : 33'(in_data_i.err);
    integ_mag = in_data_i.integ[sss_pkg::IntegW-1] ? sss_pkg::IntegW'(-in_data_i.integ)
                                                    : sss_pkg::IntegW'(in_data_i.integ);
    mul_d.mode      = in_data_i.mode;
    mul_d.ramp      = in_data_i.ramp;
    mul_d.act       = in_data_i.act;
    mul_d.err_neg   = in_data_i.err[32];
    mul_d.integ_neg = in_data_i.integ[sss_pkg::IntegW-1];
    mul_d.p_prod    = 65'(err_mag) * 65'(cfg_i.speed_kp);
    mul_d.i_lo_prod = 64'(integ_mag[31:0]) * 64'(cfg_i.ki_times_period);
    mul_d.i_hi_prod = 47'(integ_mag[46:32]) * 47'(cfg_i.ki_times_period);
  end

  // scale, restore signs, sum and clamp to the current limit
  always_comb begin
    p_mag  = mul_q.p_prod[64:16];
    i_mag  = {1'b0, mul_q.i_hi_prod} + {16'b0, mul_q.i_lo_prod[63:32]};
    p_s    = mul_q.err_neg ? -$signed({2'b00, p_mag}) : $signed({2'b00, p_mag});
    i_s    = mul_q.integ_neg ? -$signed({3'b000, i_mag}) : $signed({3'b000, i_mag});
    u      = p_s + i_s;
    cl_pos = {20'b0, cfg_i.current_limit};
    cl_neg = -cl_pos;
    if (u > cl_pos) begin
      cmd_pi = cl_pos[31:0];
    end else if (u < cl_neg) begin
      cmd_pi = cl_neg[31:0];
    end else begin
      cmd_pi = u[31:0];
    end
    unique case (mul_q.act)
      sss_pkg::ACT_PI:   res_cmd_d = cmd_pi;
      sss_pkg::ACT_ZERO: res_cmd_d = '0;
      default:           res_cmd_d = res_cmd_q;
    endcase
  end

  // stage valids
  always_comb begin
    if (mul_fire) begin
      mul_valid_d = 1'b1;
    end else if (mul_ready) begin
      mul_valid_d = 1'b0;
    end else begin
      mul_valid_d = mul_valid_q;
    end
    if (res_fire) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  // control and held command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_cmd_q   <= '0;
    end else begin
      mul_valid_q <= mul_valid_d;
      res_valid_q <= res_valid_d;
      if (res_fire) res_cmd_q <= res_cmd_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (mul_fire) mul_q <= mul_d;
    if (res_fire) begin
      res_mode_q <= mul_q.mode;
      res_ramp_q <= mul_q.ramp;
    end
  end

  assign out_data_o.mode            = res_mode_q;
  assign out_data_o.current_command = res_cmd_q;
  assign out_data_o.ramp_reference  = res_ramp_q;

endmodule

`default_nettype wire

@@ sim/servo_speed_sequencer_pi_tb.sv @@
// self-checking testbench of the servo speed sequencer with a PI speed loop
module servo_speed_sequencer_pi_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  // unused request code, answered with a result and no state change
  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam int unsigned PIPE_DEPTH  = 4;
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned PHASE_REQS  = 203;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // predictor of the sequencer and store of the status words still due
  class speed_loop_scoreboard;
    logic [31:0] kp;
    logic [31:0] ki_per;
    logic [46:0] integ_lim;
    logic [30:0] cur_lim;
    logic [30:0] ramp_inc;
    logic [31:0] pwr_ticks;
    logic [30:0] settle_bw;
    logic [30:0] stop_thr;

    mode_e       mode;
    longint      target_spd;
    longint      ramp_ref;
    longint      integ;
    longint      cur_cmd;
    logic [31:0] ticks;

    res_t        status_due[$];
    int unsigned mismatches;

    function new();
      kp         = SpeedKpRst;
      ki_per     = KiTimesPeriodRst;
      integ_lim  = IntegLimitRst;
      cur_lim    = CurrentLimitRst;
      ramp_inc   = RampStepRst;
      pwr_ticks  = PoweronTicksRst;
      settle_bw  = SettleBandRst;
      stop_thr   = StopSpeedRst;
      mode       = MODE_IDLE;
      target_spd = 0;
      ramp_ref   = 0;
      integ      = 0;
      cur_cmd    = 0;
      ticks      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [46:0] val);
      case (idx)
        CFG_SPEED_KP:        kp        = val[31:0];
        CFG_KI_TIMES_PERIOD: ki_per    = val[31:0];
        CFG_INTEG_LIMIT:     integ_lim = val;
        CFG_CURRENT_LIMIT:   cur_lim   = val[30:0];
        CFG_RAMP_STEP:       ramp_inc  = val[30:0];
        CFG_POWERON_TICKS:   pwr_ticks = val[31:0];
        CFG_SETTLE_BAND:     settle_bw = val[30:0];
        default:             stop_thr  = val[30:0];
      endcase
    endfunction

    function longint unsigned magnitude(longint x);
      if (x < 0) return -x;
      return x;
    endfunction

    // gain times magnitude, truncated after the fixed point shift
    function longint unsigned gain_product(longint unsigned a, logic [31:0] g,
                                           int unsigned sh);
      logic [95:0] prod;
      prod = {32'd0, a} * {64'd0, g};
      prod = prod >> sh;
      return prod[63:0];
    endfunction

    // PI step with clamped integrator and clamped output
    function void pi_update(longint set_spd, longint meas);
      longint err;
      longint lim;
      longint cl;
      longint p_term;
      longint i_term;
      longint u;
      err = set_spd - meas;
      lim = longint'(integ_lim);
      cl  = longint'(cur_lim);
      integ = integ + err;
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      p_term = gain_product(magnitude(err), kp, 16);
      if (err < 0) p_term = -p_term;
      i_term = gain_product(magnitude(integ), ki_per, 32);
      if (integ < 0) i_term = -i_term;
      u = p_term + i_term;
      if (u > cl) u = cl;
      if (u < -cl) u = -cl;
      cur_cmd = u;
    endfunction

    function void run_tick(longint spd, longint cur);
      longint d;
      longint st;
      longint stop_l;
      st     = longint'(ramp_inc);
      stop_l = longint'(stop_thr);
      if (ticks != 32'hFFFF_FFFF) ticks = ticks + 32'd1;
      // over-current trips everything but fault and estop
      if (mode != MODE_FAULT && mode != MODE_ESTOP && magnitude(cur) > cur_lim) begin
        mode    = MODE_FAULT;
        cur_cmd = 0;
        integ   = 0;
        return;
      end
      case (mode)
        MODE_POWERON: begin
          if (ticks > pwr_ticks) mode = MODE_INIT;
        end
        MODE_INIT: begin
          integ = 0;
          mode  = MODE_IDLE;
        end
        MODE_RAMPING: begin
          d = target_spd - ramp_ref;
          if (magnitude(d) < ramp_inc) ramp_ref = target_spd;
          else if (d > 0) ramp_ref = ramp_ref + st;
          else ramp_ref = ramp_ref - st;
          pi_update(ramp_ref, spd);
          if (magnitude(ramp_ref - target_spd) < settle_bw) mode = MODE_STEADY;
        end
        MODE_STEADY: begin
          pi_update(target_spd, spd);
        end
        MODE_DECEL: begin
          ramp_ref = ramp_ref - st;
          if (ramp_ref < 0) ramp_ref = 0;
          pi_update(ramp_ref, spd);
          if (spd < stop_l) begin
            mode     = MODE_IDLE;
            ramp_ref = 0;
          end
        end
        default: ;
      endcase
    endfunction

    // note an accepted request and queue the status it must produce
    function void take_request(logic [2:0] cmd, logic [31:0] tgt, logic [31:0] spd,
                               logic [31:0] cur);
      res_t due;
      case (cmd)
        CMD_TICK: run_tick(longint'($signed(spd)), longint'($signed(cur)));
        CMD_POWER_ON: begin
          if (mode == MODE_IDLE) mode = MODE_POWERON;
        end
        CMD_SET_TARGET: begin
          target_spd = longint'($signed(tgt));
          if (mode == MODE_IDLE || mode == MODE_STEADY || mode == MODE_POWERON ||
              mode == MODE_INIT) mode = MODE_RAMPING;
        end
        CMD_DECELERATE: begin
          if (mode == MODE_STEADY || mode == MODE_RAMPING) begin
            target_spd = 0;
            mode       = MODE_DECEL;
          end
        end
        CMD_ESTOP: begin
          mode    = MODE_ESTOP;
          cur_cmd = 0;
          integ   = 0;
        end
        CMD_CLEAR_FAULT: begin
          if (mode == MODE_FAULT) begin
            integ    = 0;
            ramp_ref = 0;
            mode     = MODE_IDLE;
          end
        end
        CMD_INJECT_FAULT: begin
          mode  = MODE_FAULT;
          integ = 0;
        end
        default: ;
      endcase
      due.mode            = mode;
      due.current_command = cur_cmd[31:0];
      due.ramp_reference  = ramp_ref[31:0];
      status_due.insert(status_due.size(), due);
    endfunction

    // compare one delivered status word with the oldest one due
    function void check_status(logic [2:0] st, logic [31:0] cc, logic [31:0] rr);
      res_t due;
      if (status_due.size() == 0) begin
        $error("status word delivered with no request outstanding");
        mismatches++;
        return;
      end
      due = status_due.pop_front();
      if (st !== due.mode) begin
        $error("machine_state: expected %0d, actual %0d", due.mode, st);
        mismatches++;
      end
      if (cc !== due.current_command) begin
        $error("current_command: expected %0d, actual %0d", due.current_command,
               $signed(cc));
        mismatches++;
      end
      if (rr !== due.ramp_reference) begin
        $error("ramp_reference: expected %0d, actual %0d", due.ramp_reference,
               $signed(rr));
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sss_req_if req_bus ();
  sss_rsp_if rsp_bus ();

  speed_loop_scoreboard loop_sb;
  int unsigned          send_idle_pct;
  int unsigned          resp_stall_pct;
  int unsigned          cycle_count = 0;

  servo_speed_sequencer_pi u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // result side back-pressure
  always @(negedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(0, 99) >= resp_stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      loop_sb.check_status(rsp_bus.machine_state, rsp_bus.current_command,
                           rsp_bus.ramp_reference);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("servo_speed_sequencer_pi verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // one request, with random sender gaps ahead of it
  task automatic send_request(logic [2:0] cmd, logic [31:0] tgt, logic [31:0] spd,
                              logic [31:0] cur);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid            <= 1'b1;
    req_bus.cmd              <= cmd;
    req_bus.target_speed     <= tgt;
    req_bus.measured_speed   <= spd;
    req_bus.measured_current <= cur;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    loop_sb.take_request(cmd, tgt, spd, cur);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [46:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    loop_sb.set_reg(idx, val);
  endtask

  task automatic apply_config(logic [31:0] kp, logic [31:0] ki, logic [46:0] il,
                              logic [30:0] cl, logic [30:0] rs, logic [31:0] pt,
                              logic [30:0] sb, logic [30:0] ss);
    write_reg(CFG_SPEED_KP, 47'(kp));
    write_reg(CFG_KI_TIMES_PERIOD, 47'(ki));
    write_reg(CFG_INTEG_LIMIT, il);
    write_reg(CFG_CURRENT_LIMIT, 47'(cl));
    write_reg(CFG_RAMP_STEP, 47'(rs));
    write_reg(CFG_POWERON_TICKS, 47'(pt));
    write_reg(CFG_SETTLE_BAND, 47'(sb));
    write_reg(CFG_STOP_SPEED, 47'(ss));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // plausible loop tuning, or anything the registers hold
  task automatic random_config(bit full_range);
    logic [31:0] kp;
    logic [31:0] ki;
    logic [46:0] il;
    logic [30:0] cl;
    logic [30:0] rs;
    logic [31:0] pt;
    logic [30:0] sb;
    logic [30:0] ss;
    if (full_range) begin
      kp = $urandom;
      ki = $urandom;
      il = 47'({$urandom, $urandom} >> 17);
      cl = 31'($urandom >> 1);
      rs = 31'($urandom >> 1);
      pt = $urandom;
      sb = 31'($urandom >> 1);
      ss = 31'($urandom >> 1);
    end else begin
      kp = $urandom_range(0, 32'h0004_0000);
      ki = $urandom >> $urandom_range(0, 20);
      il = 47'({$urandom, $urandom} >> $urandom_range(17, 45));
      cl = 31'($urandom_range(32'h0001_0000, 32'h001E_0000));
      rs = 31'($urandom_range(1, 32'h0002_0000));
      pt = $urandom_range(0, 12);
      sb = 31'($urandom_range(0, 32'h0002_0000));
      ss = 31'($urandom_range(0, 32'h0004_0000));
    end
    apply_config(kp, ki, il, cl, rs, pt, sb, ss);
  endtask

  // random request, biased towards the commands that move the machine on
  task automatic random_request();
    int unsigned r;
    logic [2:0]  cmd;
    logic [31:0] tgt;
    logic [31:0] spd;
    logic [31:0] cur;
    longint      off;
    longint      m;
    r = $urandom_range(0, 99);
    if (loop_sb.mode == MODE_FAULT && r < 25) cmd = CMD_CLEAR_FAULT;
    else if (loop_sb.mode == MODE_ESTOP && r < 25) cmd = CMD_INJECT_FAULT;
    else begin
      r = $urandom_range(0, 99);
      if (r < 56) cmd = CMD_TICK;
      else if (r < 68) cmd = CMD_SET_TARGET;
      else if (r < 74) cmd = CMD_POWER_ON;
      else if (r < 81) cmd = CMD_DECELERATE;
      else if (r < 87) cmd = CMD_CLEAR_FAULT;
      else if (r < 92) cmd = CMD_INJECT_FAULT;
      else if (r < 96) cmd = CMD_ESTOP;
      else cmd = CMD_UNUSED;
    end

    // target a few ramp steps away, small, zero, extreme or anything
    r = $urandom_range(0, 99);
    if (r < 50) begin
      off = longint'($urandom_range(0, 12)) * longint'(loop_sb.ramp_inc);
      if ($urandom_range(0, 1)) off = -off;
      off = off + (longint'($signed($urandom)) >>> 20);
      tgt = sat32(loop_sb.ramp_ref + off);
    end else if (r < 70) tgt = $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
    else if (r < 78) tgt = '0;
    else if (r < 84) tgt = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else tgt = $urandom;

    // speed near the reference, near the stop threshold, extreme or anything
    r = $urandom_range(0, 99);
    if (r < 45) begin
      off = longint'($signed($urandom)) >>> $urandom_range(8, 31);
      spd = sat32(loop_sb.ramp_ref + off);
    end else if (r < 65) begin
      off = longint'($urandom_range(0, 131072)) - 65536;
      spd = sat32(longint'(loop_sb.stop_thr) + off);
    end else if (r < 72) spd = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else spd = $urandom;

    // current mostly inside the trip level
    r = $urandom_range(0, 99);
    if (r < 85) begin
      m = longint'($urandom_range(0, loop_sb.cur_lim));
      cur = $urandom_range(0, 1) ? sat32(-m) : sat32(m);
    end else if (r < 90) cur = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else cur = $urandom;

    send_request(cmd, tgt, spd, cur);
  endtask

  // stop sending and let every outstanding status word come back
  task automatic drain();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (loop_sb.status_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  initial begin
    loop_sb                  = new();
    send_idle_pct            = 0;
    resp_stall_pct           = 0;
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = '0;
    cfg_wdata_i              = '0;
    req_bus.valid            = 1'b0;
    req_bus.cmd              = '0;
    req_bus.target_speed     = '0;
    req_bus.measured_speed   = '0;
    req_bus.measured_current = '0;
    rsp_bus.ready            = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed walk through every mode, with a short power-on count
    apply_config(SpeedKpRst, KiTimesPeriodRst, IntegLimitRst, CurrentLimitRst,
                 RampStepRst, 32'd2, SettleBandRst, StopSpeedRst);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_CLEAR_FAULT, '0, '0, '0);
    send_request(CMD_DECELERATE, '0, '0, '0);
    send_request(CMD_POWER_ON, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_SET_TARGET, 32'h7FFF_FFFF, '0, '0);
    send_request(CMD_TICK, '0, 32'h8000_0000, 32'(CurrentLimitRst));
    send_request(CMD_SET_TARGET, 32'h8000_0000, '0, '0);
    send_request(CMD_TICK, '0, 32'h7FFF_FFFF, -32'(CurrentLimitRst));
    send_request(CMD_SET_TARGET, 32'd300, '0, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_POWER_ON, '0, '0, '0);
    send_request(CMD_TICK, '0, 32'd100, '0);
    send_request(CMD_DECELERATE, '0, '0, '0);
    send_request(CMD_TICK, '0, 32'h7FFF_FFFF, '0);
    send_request(CMD_TICK, '0, 32'hFFFF_FFFF, '0);
    send_request(CMD_SET_TARGET, 32'h0005_0000, '0, '0);
    send_request(CMD_TICK, '0, '0, 32'h8000_0000);
    send_request(CMD_TICK, '0, '0, 32'h8000_0000);
    send_request(CMD_CLEAR_FAULT, '0, '0, '0);
    send_request(CMD_INJECT_FAULT, '0, '0, '0);
    send_request(CMD_ESTOP, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_INJECT_FAULT, '0, '0, '0);
    send_request(CMD_CLEAR_FAULT, '0, '0, '0);
    drain();

    // random phases over several tunings and flow-control patterns
    for (int unsigned ph = 1; ph <= PHASE_COUNT; ph++) begin
      case ((ph - 1) % 4)
        0: begin
          send_idle_pct  = 0;
          resp_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 86;
          resp_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          resp_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 36;
          resp_stall_pct = 36;
        end
      endcase
      case (ph)
        1: apply_config(SpeedKpRst, KiTimesPeriodRst, IntegLimitRst, CurrentLimitRst,
                        RampStepRst, PoweronTicksRst, SettleBandRst, StopSpeedRst);
        2: apply_config('1, '1, '1, '1, '1, '1, '1, '1);
        3: apply_config('0, '0, '0, '0, '0, '0, '0, '0);
        6: random_config(1'b1);
        default: random_config(1'b0);
      endcase
      repeat (PHASE_REQS) random_request();
      drain();
    end

    if (loop_sb.mismatches == 0) begin
      $display("servo_speed_sequencer_pi verification clean");
    end else begin
      $display("servo_speed_sequencer_pi verification failed");
    end
    $finish;
  end

endmodule
